[rtl/cbad_pkg.sv]
// ----------------------------------------------------------------------------
// Cartridge bank address decoder package
// Shared constants, codes, structs and mask helpers for the decoder pipeline.
// ----------------------------------------------------------------------------
package cbad_pkg;

    // Widest ROM size in address bits; larger settings saturate here.
    localparam int MAX_ROM_BITS = 23;
    // Widest save RAM size in address bits.
    localparam int MAX_RAM_BITS = 20;
    // ROM sizes from this many address bits up shrink the lo save RAM window.
    localparam int ROM_BIG_BITS = 21;
    // Width of the byte offset result.
    localparam int OFFSET_W = 23;

    // Map modes.
    localparam logic [3:0] MODE_NONE   = 4'd0;
    localparam logic [3:0] MODE_LO     = 4'd1;
    localparam logic [3:0] MODE_HI     = 4'd2;
    localparam logic [3:0] MODE_EXLO   = 4'd3;
    localparam logic [3:0] MODE_EXHI   = 4'd4;
    localparam logic [3:0] MODE_COPRO  = 4'd5;
    localparam logic [3:0] MODE_LODSP  = 4'd6;
    localparam logic [3:0] MODE_HIDSP  = 4'd7;
    localparam logic [3:0] MODE_DSPRAM = 4'd8;

    // Targets.
    localparam logic [2:0] TGT_NONE  = 3'd0;
    localparam logic [2:0] TGT_ROM   = 3'd1;
    localparam logic [2:0] TGT_RAM   = 3'd2;
    localparam logic [2:0] TGT_PORT  = 3'd3;
    localparam logic [2:0] TGT_DRAM  = 3'd4;
    localparam logic [2:0] TGT_COPRO = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAP_MODE = 2'd0;
    localparam logic [1:0] CFG_ROM_BITS = 2'd1;
    localparam logic [1:0] CFG_RAM_BITS = 2'd2;

    // Which size mask applies to the raw offset.
    typedef enum logic [1:0] {
        MSK_NONE,
        MSK_ROM,
        MSK_RAM
    } t_msk;

    // Configuration register contents.
    typedef struct packed {
        logic [3:0] map_mode;
        logic [4:0] rom_addr_bits;
        logic [4:0] ram_addr_bits;
    } t_cfg;

    // Stage 1 result: access fields and window hits.
    typedef struct packed {
        logic        wr;
        logic [7:0]  bank;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        lo_ram_sized;
        logic        lo_ram_plain;
        logic        rom_any;
        logic        rom_a15;
        logic        hi_ram;
        logic        ext_ram;
        logic        copro;
        logic        lodsp;
        logic        hidsp;
        logic        dsp8_port;
        logic        dsp8_dram;
    } t_class;

    // Stage 2 result: chosen target with its unmasked offset.
    typedef struct packed {
        logic [2:0]          target;
        logic [OFFSET_W-1:0] raw_off;
        t_msk                msk;
        logic                port_sel;
        logic                is_write;
        logic [7:0]          data;
    } t_sel;

    // Limit a size setting to its largest legal value.
    function automatic logic [4:0] clip_bits(input logic [4:0] b, input logic [4:0] lim);
        return (b > lim) ? lim : b;
    endfunction

    // Mask with the low n bits set.
    function automatic logic [OFFSET_W-1:0] low_mask(input logic [4:0] n);
        logic [OFFSET_W-1:0] m;
        for (int i = 0; i < OFFSET_W; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

endpackage

[rtl/cartridge_bank_address_decoder.sv]
// ----------------------------------------------------------------------------
// Cartridge bank address decoder
// Decodes one cartridge bus access per cycle, while o_busy is low, into target, offset and port.
// ----------------------------------------------------------------------------
//  Channel   Ports                                          Handshake
//  access    i_func i_bank i_addr i_wr_data                 i_start, o_busy
//  result    o_target o_offset o_port_sel o_is_write        o_strobe (one cycle)
//            o_out_data
//  config    i_cfg_index i_cfg_data                         i_cfg_valid, o_cfg_ready
//
//  Three register stages (classify, select, mask); each access produces its
//  result with o_strobe after all three, one access per cycle while o_busy
//  is low. o_busy is high during reset, clears on the clock edge after reset
//  is released and stays low; o_cfg_ready is its inverse. The pipeline never
//  stalls; the receiver must take every result in the cycle it is shown,
//  which the block does not enforce. Reset is synchronous and active low:
//  valid bits clear; map mode none, 22 ROM address bits and no save RAM.
// ----------------------------------------------------------------------------
module cartridge_bank_address_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_func,
    input  logic [7:0]                    i_bank,
    input  logic [15:0]                   i_addr,
    input  logic [7:0]                    i_wr_data,
    output logic                          o_strobe,
    output logic [2:0]                    o_target,
    output logic [cbad_pkg::OFFSET_W-1:0] o_offset,
    output logic                          o_port_sel,
    output logic                          o_is_write,
    output logic [7:0]                    o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [4:0]                    i_cfg_data
);

    logic             r_busy;
    cbad_pkg::t_cfg   r_cfg;
    logic             accept;
    logic             v1;
    logic             v2;
    cbad_pkg::t_class cls;
    cbad_pkg::t_sel   sel;

    assign accept      = i_start && !r_busy;
    assign o_busy      = r_busy;
    assign o_cfg_ready = !r_busy;

    // Busy during reset, configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy              <= 1'b1;
            r_cfg.map_mode      <= cbad_pkg::MODE_NONE;
            r_cfg.rom_addr_bits <= 5'd22;
            r_cfg.ram_addr_bits <= 5'd0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && !r_busy) begin
                case (i_cfg_index)
                    cbad_pkg::CFG_MAP_MODE: r_cfg.map_mode      <= i_cfg_data[3:0];
                    cbad_pkg::CFG_ROM_BITS: r_cfg.rom_addr_bits <= i_cfg_data;
                    cbad_pkg::CFG_RAM_BITS: r_cfg.ram_addr_bits <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Stage 1: window classification.
    cbad_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_func    (i_func),
        .i_bank    (i_bank),
        .i_addr    (i_addr),
        .i_wr_data (i_wr_data),
        .i_cfg     (r_cfg),
        .o_valid   (v1),
        .o_cls     (cls)
    );

    // Stage 2: target selection.
    cbad_select u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (v1),
        .i_cls      (cls),
        .i_map_mode (r_cfg.map_mode),
        .o_valid    (v2),
        .o_sel      (sel)
    );

    // Stage 3: size masking and result register.
    cbad_mask u_mask (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (v2),
        .i_sel           (sel),
        .i_rom_addr_bits (r_cfg.rom_addr_bits),
        .i_ram_addr_bits (r_cfg.ram_addr_bits),
        .o_strobe        (o_strobe),
        .o_target        (o_target),
        .o_offset        (o_offset),
        .o_port_sel      (o_port_sel),
        .o_is_write      (o_is_write),
        .o_out_data      (o_out_data)
    );

`ifndef SYNTHESIS
    // Every transfer yields exactly one result, after the classify, select and mask registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("access transfer without result three cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 3))
        else $error("result without a matching access transfer");

    // A write is only reported with a real target.
    a_write_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_write) |-> (o_target != cbad_pkg::TGT_NONE))
        else $error("write reported without a target");

    // Port select and offset follow the target kind.
    a_port_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((!o_port_sel || o_target == cbad_pkg::TGT_PORT)
                   && ((o_target != cbad_pkg::TGT_NONE && o_target != cbad_pkg::TGT_PORT)
                       || o_offset == '0)))
        else $error("port select or offset inconsistent with target");
`endif

endmodule

[rtl/cbad_classify.sv]
// ----------------------------------------------------------------------------
// Cartridge decoder, stage 1: window classification
// Registers the access and the hits of every bank and address window.
// ----------------------------------------------------------------------------
module cbad_classify (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_func,
    input  logic [7:0]          i_bank,
    input  logic [15:0]         i_addr,
    input  logic [7:0]          i_wr_data,
    input  cbad_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output cbad_pkg::t_class    o_cls
);

    logic             ram_p;
    logic             rom_big;
    logic [4:0]       rom_sat;
    logic             lo_banks;
    logic             a_6x;
    logic             r_valid;
    cbad_pkg::t_class r_cls;
    cbad_pkg::t_class n_cls;

    // Size-dependent conditions.
    assign rom_sat = cbad_pkg::clip_bits(i_cfg.rom_addr_bits, 5'(cbad_pkg::MAX_ROM_BITS));
    assign rom_big = (rom_sat >= 5'(cbad_pkg::ROM_BIG_BITS));
    assign ram_p   = (i_cfg.ram_addr_bits != 5'd0);

    // Common windows: banks 70-7D and F0-FF, and addresses 6000-7FFF.
    assign lo_banks = ((i_bank >= 8'h70) && (i_bank < 8'h7E)) || (i_bank >= 8'hF0);
    assign a_6x     = (i_addr[15:13] == 3'b011);

    // Window hits for every mode; stage 2 picks among them.
    always_comb begin
        n_cls.wr           = i_func;
        n_cls.bank         = i_bank;
        n_cls.addr         = i_addr;
        n_cls.data         = i_wr_data;
        n_cls.lo_ram_sized = lo_banks && (!rom_big || !i_addr[15]) && ram_p;
        n_cls.lo_ram_plain = lo_banks && !i_addr[15] && ram_p;
        n_cls.rom_any      = i_addr[15] || i_bank[6];
        n_cls.rom_a15      = i_addr[15];
        n_cls.hi_ram       = (i_bank[6:5] == 2'b01) && a_6x && ram_p;
        n_cls.ext_ram      = !i_bank[6] && a_6x && ram_p;
        n_cls.copro        = !i_bank[6] && a_6x;
        n_cls.lodsp        = ((i_bank[6:4] == 3'h3) && i_addr[15])
                          || ((i_bank[6:4] == 3'h6) && !i_addr[15]);
        n_cls.hidsp        = (i_bank[6:5] == 2'b00) && a_6x;
        n_cls.dsp8_port    = (i_bank[6:3] == 4'b1100) && (i_addr[15:14] == 2'b00);
        n_cls.dsp8_dram    = (i_bank[6:3] == 4'b1101) && !i_addr[15];
    end

    // Stage register; the valid bit is control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (i_valid) begin
            r_cls <= n_cls;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule

[rtl/cbad_select.sv]
// ----------------------------------------------------------------------------
// Cartridge decoder, stage 2: target selection
// Picks the target for the map mode and forms its unmasked offset.
// ----------------------------------------------------------------------------
module cbad_select (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cbad_pkg::t_class i_cls,
    input  logic [3:0]       i_map_mode,
    output logic             o_valid,
    output cbad_pkg::t_sel   o_sel
);

    logic [cbad_pkg::OFFSET_W-1:0] lo_ram_raw;
    logic [cbad_pkg::OFFSET_W-1:0] lo_rom_raw;
    logic [cbad_pkg::OFFSET_W-1:0] exlo_rom_raw;
    logic [cbad_pkg::OFFSET_W-1:0] hi_ram_raw;
    logic [cbad_pkg::OFFSET_W-1:0] ext_ram_raw;
    logic [cbad_pkg::OFFSET_W-1:0] hi_rom_raw;
    logic [cbad_pkg::OFFSET_W-1:0] copro_raw;
    logic [cbad_pkg::OFFSET_W-1:0] dram_raw;
    logic [2:0]                    tgt;
    logic [cbad_pkg::OFFSET_W-1:0] raw;
    cbad_pkg::t_msk                msk;
    logic                          port;
    logic                          r_valid;
    cbad_pkg::t_sel                r_sel;
    cbad_pkg::t_sel                n_sel;

    // Raw offsets of every window; address bit 15 overlaps bank bit 0 in lo save RAM.
    assign lo_ram_raw   = {4'b0, i_cls.bank[3:1], i_cls.bank[0] | i_cls.addr[15],
                           i_cls.addr[14:0]};
    assign lo_rom_raw   = {1'b0, i_cls.bank[6:0], i_cls.addr[14:0]};
    assign exlo_rom_raw = {!i_cls.bank[7], i_cls.bank[6:0], i_cls.addr[14:0]};
    assign hi_ram_raw   = {5'b0, i_cls.bank[4:0], i_cls.addr[12:0]};
    assign ext_ram_raw  = {4'b0, i_cls.bank[5:0], i_cls.addr[12:0]};
    assign hi_rom_raw   = {(i_map_mode == cbad_pkg::MODE_EXHI) && !i_cls.bank[7],
                           i_cls.bank[5:0], i_cls.addr};
    assign copro_raw    = {10'b0, i_cls.addr[12:0]};
    assign dram_raw     = {11'b0, i_cls.addr[11:0]};

    // Priority decode per map mode.
    always_comb begin
        tgt  = cbad_pkg::TGT_NONE;
        raw  = '0;
        msk  = cbad_pkg::MSK_NONE;
        port = 1'b0;
        case (i_map_mode)
            cbad_pkg::MODE_LO, cbad_pkg::MODE_EXLO: begin
                if (i_cls.wr) begin
                    if (i_cls.lo_ram_sized) begin
                        tgt = cbad_pkg::TGT_RAM;
                        raw = lo_ram_raw;
                        msk = cbad_pkg::MSK_RAM;
                    end
                end else if (i_map_mode == cbad_pkg::MODE_LO) begin
                    if (i_cls.lo_ram_sized) begin
                        tgt = cbad_pkg::TGT_RAM;
                        raw = lo_ram_raw;
                        msk = cbad_pkg::MSK_RAM;
                    end else if (i_cls.rom_any) begin
                        tgt = cbad_pkg::TGT_ROM;
                        raw = lo_rom_raw;
                        msk = cbad_pkg::MSK_ROM;
                    end
                end else begin
                    if (i_cls.lo_ram_plain) begin
                        tgt = cbad_pkg::TGT_RAM;
                        raw = lo_ram_raw;
                        msk = cbad_pkg::MSK_RAM;
                    end else if (i_cls.rom_a15) begin
                        tgt = cbad_pkg::TGT_ROM;
                        raw = exlo_rom_raw;
                        msk = cbad_pkg::MSK_ROM;
                    end
                end
            end
            cbad_pkg::MODE_HI, cbad_pkg::MODE_EXHI: begin
                if (i_cls.wr) begin
                    if (i_cls.hi_ram) begin
                        tgt = cbad_pkg::TGT_RAM;
                        raw = hi_ram_raw;
                        msk = cbad_pkg::MSK_RAM;
                    end
                end else if (i_map_mode == cbad_pkg::MODE_EXHI && i_cls.ext_ram) begin
                    tgt = cbad_pkg::TGT_RAM;
                    raw = ext_ram_raw;
                    msk = cbad_pkg::MSK_RAM;
                end else if (i_map_mode == cbad_pkg::MODE_HI && i_cls.hi_ram) begin
                    tgt = cbad_pkg::TGT_RAM;
                    raw = hi_ram_raw;
                    msk = cbad_pkg::MSK_RAM;
                end else if (i_cls.rom_any) begin
                    tgt = cbad_pkg::TGT_ROM;
                    raw = hi_rom_raw;
                    msk = cbad_pkg::MSK_ROM;
                end
            end
            cbad_pkg::MODE_COPRO: begin
                if (i_cls.copro) begin
                    tgt = cbad_pkg::TGT_COPRO;
                    raw = copro_raw;
                end else if (i_cls.lo_ram_plain) begin
                    tgt = cbad_pkg::TGT_RAM;
                    raw = lo_ram_raw;
                    msk = cbad_pkg::MSK_RAM;
                end else if (!i_cls.wr && i_cls.rom_any) begin
                    tgt = cbad_pkg::TGT_ROM;
                    raw = lo_rom_raw;
                    msk = cbad_pkg::MSK_ROM;
                end
            end
            cbad_pkg::MODE_LODSP: begin
                if (i_cls.lo_ram_plain) begin
                    tgt = cbad_pkg::TGT_RAM;
                    raw = lo_ram_raw;
                    msk = cbad_pkg::MSK_RAM;
                end else if (i_cls.lodsp) begin
                    tgt  = cbad_pkg::TGT_PORT;
                    port = !i_cls.addr[14];
                end else if (!i_cls.wr && i_cls.rom_any) begin
                    tgt = cbad_pkg::TGT_ROM;
                    raw = lo_rom_raw;
                    msk = cbad_pkg::MSK_ROM;
                end
            end
            cbad_pkg::MODE_HIDSP: begin
                if (i_cls.hidsp) begin
                    tgt  = cbad_pkg::TGT_PORT;
                    port = !i_cls.addr[12];
                end else if (i_cls.hi_ram) begin
                    tgt = cbad_pkg::TGT_RAM;
                    raw = hi_ram_raw;
                    msk = cbad_pkg::MSK_RAM;
                end else if (!i_cls.wr && i_cls.rom_any) begin
                    tgt = cbad_pkg::TGT_ROM;
                    raw = hi_rom_raw;
                    msk = cbad_pkg::MSK_ROM;
                end
            end
            cbad_pkg::MODE_DSPRAM: begin
                if (i_cls.dsp8_port) begin
                    tgt  = cbad_pkg::TGT_PORT;
                    port = !i_cls.addr[0];
                end else if (i_cls.dsp8_dram) begin
                    tgt = cbad_pkg::TGT_DRAM;
                    raw = dram_raw;
                end else if (i_cls.lo_ram_sized) begin
                    tgt = cbad_pkg::TGT_RAM;
                    raw = lo_ram_raw;
                    msk = cbad_pkg::MSK_RAM;
                end else if (!i_cls.wr && i_cls.rom_a15) begin
                    tgt = cbad_pkg::TGT_ROM;
                    raw = lo_rom_raw;
                    msk = cbad_pkg::MSK_ROM;
                end
            end
            default: begin
                tgt = cbad_pkg::TGT_NONE;
            end
        endcase
    end

    // Write qualification travels with the selection.
    always_comb begin
        n_sel.target   = tgt;
        n_sel.raw_off  = raw;
        n_sel.msk      = msk;
        n_sel.port_sel = port;
        n_sel.is_write = i_cls.wr && (tgt != cbad_pkg::TGT_NONE);
        n_sel.data     = (i_cls.wr && (tgt != cbad_pkg::TGT_NONE)) ? i_cls.data : 8'h00;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (i_valid) begin
            r_sel <= n_sel;
        end
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;

endmodule

[rtl/cbad_mask.sv]
// ----------------------------------------------------------------------------
// Cartridge decoder, stage 3: size masking
// Masks ROM and save RAM offsets by the configured sizes and registers results.
// ----------------------------------------------------------------------------
module cbad_mask (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  cbad_pkg::t_sel                i_sel,
    input  logic [4:0]                    i_rom_addr_bits,
    input  logic [4:0]                    i_ram_addr_bits,
    output logic                          o_strobe,
    output logic [2:0]                    o_target,
    output logic [cbad_pkg::OFFSET_W-1:0] o_offset,
    output logic                          o_port_sel,
    output logic                          o_is_write,
    output logic [7:0]                    o_out_data
);

    logic [cbad_pkg::OFFSET_W-1:0] rom_mask;
    logic [cbad_pkg::OFFSET_W-1:0] ram_mask;
    logic [cbad_pkg::OFFSET_W-1:0] n_offset;
    logic                          r_strobe;
    logic [2:0]                    r_target;
    logic [cbad_pkg::OFFSET_W-1:0] r_offset;
    logic                          r_port_sel;
    logic                          r_is_write;
    logic [7:0]                    r_out_data;

    // Size masks from the saturated size settings.
    assign rom_mask = cbad_pkg::low_mask(
        cbad_pkg::clip_bits(i_rom_addr_bits, 5'(cbad_pkg::MAX_ROM_BITS)));
    assign ram_mask = cbad_pkg::low_mask(
        cbad_pkg::clip_bits(i_ram_addr_bits, 5'(cbad_pkg::MAX_RAM_BITS)));

    // Apply the mask that the selection asks for.
    always_comb begin
        case (i_sel.msk)
            cbad_pkg::MSK_ROM: n_offset = i_sel.raw_off & rom_mask;
            cbad_pkg::MSK_RAM: n_offset = i_sel.raw_off & ram_mask;
            cbad_pkg::MSK_NONE: n_offset = i_sel.raw_off;
            default: n_offset = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
        if (i_valid) begin
            r_target   <= i_sel.target;
            r_offset   <= n_offset;
            r_port_sel <= i_sel.port_sel;
            r_is_write <= i_sel.is_write;
            r_out_data <= i_sel.data;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_target   = r_target;
    assign o_offset   = r_offset;
    assign o_port_sel = r_port_sel;
    assign o_is_write = r_is_write;
    assign o_out_data = r_out_data;

endmodule

[verif/cartridge_bank_address_decoder_tb.sv]
// ----------------------------------------------------------------------------
// Cartridge bank address decoder testbench
// Sends bus accesses under many map modes and ROM and save RAM sizes. Each
// access is decoded by a model in the bench, and every result strobe from the
// decoder is compared field by field with the oldest pending decode.
// ----------------------------------------------------------------------------
module cartridge_bank_address_decoder_tb;

    // Register index with no register behind it.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    // Cycles to let pass after the last result before a register write.
    localparam int SETTLE_CYCLES = 4;
    // Cycles to wait for outstanding results before calling them missing.
    localparam int RESULT_WAIT = 200;

    // One decoded access as the result ports show it.
    typedef struct packed {
        logic [2:0]                    target;
        logic [cbad_pkg::OFFSET_W-1:0] offset;
        logic                          port_sel;
        logic                          is_write;
        logic [7:0]                    out_data;
    } t_bus_decode;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    logic                          o_busy;
    logic                          i_func;
    logic [7:0]                    i_bank;
    logic [15:0]                   i_addr;
    logic [7:0]                    i_wr_data;
    logic                          o_strobe;
    logic [2:0]                    o_target;
    logic [cbad_pkg::OFFSET_W-1:0] o_offset;
    logic                          o_port_sel;
    logic                          o_is_write;
    logic [7:0]                    o_out_data;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index;
    logic [4:0]                    i_cfg_data;

    // Bench copy of the configuration registers.
    logic [3:0]  cfg_mode;
    logic [4:0]  cfg_rom_bits;
    logic [4:0]  cfg_ram_bits;

    t_bus_decode expected_decodes[$];
    int unsigned mismatches;
    int unsigned accesses;
    int unsigned settings_loaded;
    int unsigned target_hits[6];
    bit          sender_idles;

    cartridge_bank_address_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_func      (i_func),
        .i_bank      (i_bank),
        .i_addr      (i_addr),
        .i_wr_data   (i_wr_data),
        .o_strobe    (o_strobe),
        .o_target    (o_target),
        .o_offset    (o_offset),
        .o_port_sel  (o_port_sel),
        .o_is_write  (o_is_write),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock, period 10.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Decode one access under the current bench configuration.
    function automatic t_bus_decode predict_decode(input logic wr, input logic [7:0] bank,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] data);
        int unsigned rom_b, ram_b, rom_m, ram_m, b7, off, hi_half;
        int unsigned lo_ram_off, lo_rom_off, exlo_rom_off;
        int unsigned hi_ram_off, hi_rom_off, ex_ram_off, ex_rom_off;
        bit ram_on, lo_banks, win, lo_plain, lo_sized, lo_rom_any;
        bit hi_ram, hi_rom, ex_ram, copro, lodsp, hidsp, d8_port, d8_dram, port;
        logic [2:0] tgt;
        t_bus_decode r;

        // Size masks, saturated at the widest legal sizes.
        rom_b = (cfg_rom_bits > cbad_pkg::MAX_ROM_BITS) ? cbad_pkg::MAX_ROM_BITS : cfg_rom_bits;
        ram_b = (cfg_ram_bits > cbad_pkg::MAX_RAM_BITS) ? cbad_pkg::MAX_RAM_BITS : cfg_ram_bits;
        rom_m = (32'd1 << rom_b) - 32'd1;
        ram_m = (32'd1 << ram_b) - 32'd1;
        ram_on = (cfg_ram_bits != 5'd0);
        b7 = int'(bank[6:0]);
        hi_half = bank[7] ? 32'd0 : 32'h400000;

        // Window hits shared by several modes.
        win = (addr >= 16'h6000) && (addr < 16'h8000);
        lo_banks = ((bank >= 8'h70) && (bank < 8'h7E)) || (bank >= 8'hF0);
        lo_plain = lo_banks && ram_on && !addr[15];
        lo_sized = lo_banks && ram_on && ((rom_b < cbad_pkg::ROM_BIG_BITS) || !addr[15]);
        lo_rom_any = addr[15] || (b7 >= 32'h40);
        hi_ram = (b7 >= 32'h20) && (b7 < 32'h40) && win && ram_on;
        hi_rom = addr[15] || (b7 >= 32'h40);
        ex_ram = (b7 < 32'h40) && win && ram_on;
        copro = (b7 < 32'h40) && win;
        lodsp = ((bank[6:4] == 3'b011) && addr[15]) || ((bank[6:4] == 3'b110) && !addr[15]);
        hidsp = (b7 < 32'h20) && win;
        d8_port = (bank[6:3] == 4'b1100) && (addr[15:14] == 2'b00);
        d8_dram = (bank[6:3] == 4'b1101) && !addr[15];

        // Candidate offsets.
        lo_ram_off = ((int'(bank[3:0]) << 15) | int'(addr)) & ram_m;
        lo_rom_off = ((b7 << 15) | int'(addr[14:0])) & rom_m;
        exlo_rom_off = ((b7 << 15) | hi_half | int'(addr[14:0])) & rom_m;
        hi_ram_off = (((b7 & 32'h1F) << 13) | int'(addr[12:0])) & ram_m;
        hi_rom_off = (((b7 & 32'h3F) << 16) | int'(addr)) & rom_m;
        ex_ram_off = (((b7 & 32'h3F) << 13) | int'(addr[12:0])) & ram_m;
        ex_rom_off = (((b7 & 32'h3F) << 16) | hi_half | int'(addr)) & rom_m;

        tgt = cbad_pkg::TGT_NONE;
        off = 0;
        port = 1'b0;
        case (cfg_mode)
            cbad_pkg::MODE_LO: begin
                if (lo_sized) begin
                    tgt = cbad_pkg::TGT_RAM;
                    off = lo_ram_off;
                end else if (!wr && lo_rom_any) begin
                    tgt = cbad_pkg::TGT_ROM;
                    off = lo_rom_off;
                end
            end
            cbad_pkg::MODE_EXLO: begin
                // Writes use the size-dependent window, reads the plain one.
                if (wr ? lo_sized : lo_plain) begin
                    tgt = cbad_pkg::TGT_RAM;
                    off = lo_ram_off;
                end else if (!wr && addr[15]) begin
                    tgt = cbad_pkg::TGT_ROM;
                    off = exlo_rom_off;
                end
            end
            cbad_pkg::MODE_HI: begin
                if (hi_ram) begin
                    tgt = cbad_pkg::TGT_RAM;
                    off = hi_ram_off;
                end else if (!wr && hi_rom) begin
                    tgt = cbad_pkg::TGT_ROM;
                    off = hi_rom_off;
                end
            end
            cbad_pkg::MODE_EXHI: begin
                // Reads see save RAM from bank 00 up, writes only from 20 up.
                if (wr) begin
                    if (hi_ram) begin
                        tgt = cbad_pkg::TGT_RAM;
                        off = hi_ram_off;
                    end
                end else if (ex_ram) begin
                    tgt = cbad_pkg::TGT_RAM;
                    off = ex_ram_off;
                end else if (hi_rom) begin
                    tgt = cbad_pkg::TGT_ROM;
                    off = ex_rom_off;
                end
            end
            cbad_pkg::MODE_COPRO: begin
                if (copro) begin
                    tgt = cbad_pkg::TGT_COPRO;
                    off = int'(addr[12:0]);
                end else if (lo_plain) begin
                    tgt = cbad_pkg::TGT_RAM;
                    off = lo_ram_off;
                end else if (!wr && lo_rom_any) begin
                    tgt = cbad_pkg::TGT_ROM;
                    off = lo_rom_off;
                end
            end
            cbad_pkg::MODE_LODSP: begin
                if (lo_plain) begin
                    tgt = cbad_pkg::TGT_RAM;
                    off = lo_ram_off;
                end else if (lodsp) begin
                    tgt = cbad_pkg::TGT_PORT;
                    port = !addr[14];
                end else if (!wr && lo_rom_any) begin
                    tgt = cbad_pkg::TGT_ROM;
                    off = lo_rom_off;
                end
            end
            cbad_pkg::MODE_HIDSP: begin
                if (hidsp) begin
                    tgt = cbad_pkg::TGT_PORT;
                    port = !addr[12];
                end else if (hi_ram) begin
                    tgt = cbad_pkg::TGT_RAM;
                    off = hi_ram_off;
                end else if (!wr && hi_rom) begin
                    tgt = cbad_pkg::TGT_ROM;
                    off = hi_rom_off;
                end
            end
            cbad_pkg::MODE_DSPRAM: begin
                if (d8_port) begin
                    tgt = cbad_pkg::TGT_PORT;
                    port = !addr[0];
                end else if (d8_dram) begin
                    tgt = cbad_pkg::TGT_DRAM;
                    off = int'(addr[11:0]);
                end else if (lo_sized) begin
                    tgt = cbad_pkg::TGT_RAM;
                    off = lo_ram_off;
                end else if (!wr && addr[15]) begin
                    tgt = cbad_pkg::TGT_ROM;
                    off = lo_rom_off;
                end
            end
            default: begin
                tgt = cbad_pkg::TGT_NONE;
            end
        endcase

        r.target = tgt;
        r.offset = off[cbad_pkg::OFFSET_W-1:0];
        r.port_sel = (tgt == cbad_pkg::TGT_PORT) && port;
        r.is_write = wr && (tgt != cbad_pkg::TGT_NONE);
        r.out_data = r.is_write ? data : 8'h00;
        return r;
    endfunction

    // Report one field that differs from its expected value.
    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Watch both channels at each rising edge: queue decodes for accepted
    // accesses, check result strobes and track register writes.
    always @(posedge i_clk) begin : monitor
        t_bus_decode want;
        if (!i_rst_n) begin
            cfg_mode = cbad_pkg::MODE_NONE;
            cfg_rom_bits = 5'd22;
            cfg_ram_bits = 5'd0;
        end else begin
            if (i_start && !o_busy) begin
                expected_decodes.push_back(predict_decode(i_func, i_bank, i_addr, i_wr_data));
                accesses++;
            end
            if (o_strobe) begin
                if (expected_decodes.size() == 0) begin
                    $display("%0t: result with no access pending, actual target %0d offset %0h",
                             $time, o_target, o_offset);
                    mismatches++;
                end else begin
                    want = expected_decodes.pop_front();
                    compare_field("target", 32'(want.target), 32'(o_target));
                    compare_field("offset", 32'(want.offset), 32'(o_offset));
                    compare_field("port_sel", 32'(want.port_sel), 32'(o_port_sel));
                    compare_field("is_write", 32'(want.is_write), 32'(o_is_write));
                    compare_field("out_data", 32'(want.out_data), 32'(o_out_data));
                end
                if (o_target < 3'd6) begin
                    target_hits[o_target]++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cbad_pkg::CFG_MAP_MODE: cfg_mode = i_cfg_data[3:0];
                    cbad_pkg::CFG_ROM_BITS: cfg_rom_bits = i_cfg_data;
                    cbad_pkg::CFG_RAM_BITS: cfg_ram_bits = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Present one access, after a random gap while sender_idles is set, and hold it until the transfer.
    task automatic drive_access(input logic func, input logic [7:0] bank,
                                input logic [15:0] addr, input logic [7:0] data);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_func <= func;
        i_bank <= bank;
        i_addr <= addr;
        i_wr_data <= data;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Stop sending and wait for every pending result, then settle.
    task automatic wait_quiet(input int settle);
        int spins;
        @(negedge i_clk);
        i_start <= 1'b0;
        spins = 0;
        while (expected_decodes.size() != 0 && spins < RESULT_WAIT) begin
            @(negedge i_clk);
            spins++;
        end
        if (expected_decodes.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_decodes.size());
            mismatches += expected_decodes.size();
            expected_decodes.delete();
        end
        repeat (settle) @(negedge i_clk);
    endtask

    // One register write transfer.
    task automatic write_setting(input logic [1:0] index, input logic [4:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain the decoder, then write all three registers.
    task automatic load_settings(input logic [3:0] mode, input logic [4:0] rom_bits,
                                 input logic [4:0] ram_bits);
        wait_quiet(SETTLE_CYCLES);
        write_setting(cbad_pkg::CFG_MAP_MODE, 5'(mode));
        write_setting(cbad_pkg::CFG_ROM_BITS, rom_bits);
        write_setting(cbad_pkg::CFG_RAM_BITS, ram_bits);
        settings_loaded++;
    endtask

    // Out of reset the map mode is none, so nothing is decoded.
    task automatic test_reset_defaults();
        drive_access(1'b0, 8'h80, 16'h8000, 8'h00);
        drive_access(1'b1, 8'h70, 16'h0000, 8'hFF);
    endtask

    // Lo and extended lo maps, with the save RAM window shrinking for big ROMs.
    task automatic test_lo_maps();
        load_settings(cbad_pkg::MODE_LO, 5'd23, 5'd20);
        drive_access(1'b0, 8'h80, 16'hFFFF, 8'h00);
        drive_access(1'b1, 8'h70, 16'h0000, 8'h5A);
        drive_access(1'b1, 8'h00, 16'h8000, 8'hC3);
        drive_access(1'b0, 8'hFF, 16'hFFFF, 8'h00);
        load_settings(cbad_pkg::MODE_LO, 5'd15, 5'd1);
        drive_access(1'b1, 8'h7D, 16'hFFFF, 8'h81);
        drive_access(1'b0, 8'h7E, 16'h0000, 8'h00);
        load_settings(cbad_pkg::MODE_EXLO, 5'd22, 5'd13);
        drive_access(1'b0, 8'h70, 16'h1234, 8'h00);
        drive_access(1'b0, 8'h00, 16'h8000, 8'h00);
    endtask

    // Hi and extended hi maps.
    task automatic test_hi_maps();
        load_settings(cbad_pkg::MODE_HI, 5'd22, 5'd13);
        drive_access(1'b0, 8'h20, 16'h6000, 8'h00);
        drive_access(1'b1, 8'hBF, 16'h7FFF, 8'h3C);
        load_settings(cbad_pkg::MODE_EXHI, 5'd23, 5'd13);
        drive_access(1'b0, 8'h00, 16'h6000, 8'h00);
        drive_access(1'b0, 8'h40, 16'h0000, 8'h00);
        drive_access(1'b1, 8'h00, 16'h6000, 8'h99);
    endtask

    // Coprocessor window, both DSP port maps and the DSP data RAM map.
    task automatic test_coprocessor_dsp();
        load_settings(cbad_pkg::MODE_COPRO, 5'd20, 5'd15);
        drive_access(1'b0, 8'h3F, 16'h6000, 8'h00);
        drive_access(1'b1, 8'h80, 16'h7FFF, 8'h7E);
        load_settings(cbad_pkg::MODE_LODSP, 5'd20, 5'd11);
        drive_access(1'b0, 8'h30, 16'h8000, 8'h00);
        drive_access(1'b1, 8'hE0, 16'h4000, 8'h12);
        load_settings(cbad_pkg::MODE_HIDSP, 5'd21, 5'd13);
        drive_access(1'b0, 8'h00, 16'h6000, 8'h00);
        drive_access(1'b1, 8'h1F, 16'h7000, 8'h34);
        load_settings(cbad_pkg::MODE_DSPRAM, 5'd20, 5'd11);
        drive_access(1'b0, 8'h60, 16'h0000, 8'h00);
        drive_access(1'b1, 8'h6F, 16'h0FFF, 8'hE7);
        drive_access(1'b0, 8'h40, 16'h0000, 8'h00);
    endtask

    // Unused index, map modes above the last and sizes above their limits.
    task automatic test_size_limits();
        wait_quiet(SETTLE_CYCLES);
        write_setting(CFG_UNUSED, 5'd31);
        write_setting(cbad_pkg::CFG_MAP_MODE, 5'd31);
        drive_access(1'b0, 8'h80, 16'h8000, 8'h00);
        load_settings(cbad_pkg::MODE_LO, 5'd31, 5'd31);
        drive_access(1'b0, 8'hFF, 16'hFFFF, 8'h00);
        drive_access(1'b1, 8'hF0, 16'h7FFF, 8'hFF);
    endtask

    // Random accesses aimed at window edges, across many register settings.
    task automatic test_random_accesses();
        logic [3:0]  mode;
        logic [4:0]  rom_bits;
        logic [4:0]  ram_bits;
        logic [7:0]  bank;
        logic [15:0] addr;
        for (int phase = 0; phase < 36; phase++) begin
            mode = (phase < 27) ? 4'(phase % 9) : 4'($urandom_range(0, 15));
            case (phase % 5)
                0: rom_bits = 5'd23;
                1: rom_bits = 5'd15;
                2: rom_bits = 5'd20;
                3: rom_bits = 5'd21;
                default: rom_bits = 5'($urandom_range(0, 31));
            endcase
            case (phase % 4)
                0: ram_bits = 5'd20;
                1: ram_bits = 5'd0;
                2: ram_bits = 5'($urandom_range(1, 19));
                default: ram_bits = 5'($urandom_range(0, 31));
            endcase
            load_settings(mode, rom_bits, ram_bits);
            sender_idles = (phase % 4 != 3);
            for (int n = 0; n < 45; n++) begin
                // Bank: mostly one of the decode regions, either half.
                case ($urandom_range(0, 7))
                    0, 1: bank = 8'($urandom_range(0, 255));
                    2: bank = 8'($urandom_range(8'h00, 8'h1F));
                    3: bank = 8'($urandom_range(8'h20, 8'h3F));
                    4: bank = 8'($urandom_range(8'h40, 8'h5F));
                    5: bank = 8'($urandom_range(8'h60, 8'h6F));
                    default: bank = 8'($urandom_range(8'h70, 8'h7F));
                endcase
                bank[7] = bank[7] | 1'($urandom_range(0, 1));
                // Address: a window, a boundary or anything.
                case ($urandom_range(0, 5))
                    0: addr = 16'h6000 | 16'($urandom_range(0, 16'h1FFF));
                    1: addr = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
                    2: addr = 16'($urandom_range(0, 16'h7FFF));
                    3: addr = 16'($urandom_range(0, 16'h3FFF));
                    4: addr = 16'(32'h1000 * $urandom_range(0, 16)) - 16'($urandom_range(0, 1));
                    default: addr = 16'($urandom_range(0, 16'hFFFF));
                endcase
                drive_access(1'($urandom_range(0, 1)), bank, addr, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_func = 1'b0;
        i_bank = 8'h00;
        i_addr = 16'h0000;
        i_wr_data = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_index = cbad_pkg::CFG_MAP_MODE;
        i_cfg_data = 5'd0;
        mismatches = 0;
        accesses = 0;
        settings_loaded = 0;
        sender_idles = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_lo_maps();
        test_hi_maps();
        test_coprocessor_dsp();
        test_size_limits();
        test_random_accesses();
        wait_quiet(8);

        $display("Decoded %0d accesses under %0d register settings.", accesses, settings_loaded);
        $display("Targets seen: none %0d, ROM %0d, save RAM %0d, port %0d, data RAM %0d, copro %0d",
                 target_hits[0], target_hits[1], target_hits[2], target_hits[3],
                 target_hits[4], target_hits[5]);
        if (mismatches == 0) begin
            $display("cartridge_bank_address_decoder: match");
        end else begin
            $display("cartridge_bank_address_decoder: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5000000;
        $display("%0t: run did not complete in time", $time);
        $display("cartridge_bank_address_decoder: mismatch");
        $finish;
    end

endmodule
